// File: design/npm_pkg.sv
// Package for the NTT polynomial multiplier: widths, reset values,
// register codes, sequencer states and the structs passed between modules.
// No dependencies.
`default_nettype none

package npm_pkg;

    localparam int DATA_W         = 31;
    localparam int LOG_W          = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int MAX_POINTS_DEF = 64;

    localparam logic [LOG_W-1:0]  LOG_SIZE_RST = 3'd6;
    localparam logic [DATA_W-1:0] MODULUS_RST  = 31'd2013265921;
    localparam logic [DATA_W-1:0] FACTOR_RST   = 31'd1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOG_SIZE     = 3'd0,
        REG_MODULUS      = 3'd1,
        REG_ROOT         = 3'd2,
        REG_INVERSE_ROOT = 3'd3,
        REG_INVERSE_SIZE = 3'd4
    } cfg_reg_t;

    // Which transform is running
    typedef enum logic [1:0] {
        PH_FWD_A,
        PH_FWD_B,
        PH_INV
    } phase_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_MUL,
        S_TX_INIT,
        S_TX_W,
        S_PERM_RD,
        S_PERM_RD2,
        S_PERM_RD3,
        S_PERM_R1,
        S_PERM_R2,
        S_PERM_WR,
        S_STAGE_INIT,
        S_SQ,
        S_SQ_W,
        S_BF_RD,
        S_BF_RD2,
        S_BF_RD3,
        S_BF_X,
        S_BF_T,
        S_PW_RD,
        S_PW_RD2,
        S_PW_WR,
        S_OUT_INIT,
        S_OUT_W,
        S_OUT_RD,
        S_OUT_RD2,
        S_OUT_EMIT
    } state_t;

    // Settings as used by the sequencer
    typedef struct packed {
        logic [LOG_W-1:0]  lg;
        logic [DATA_W-1:0] p;
        logic              one;
        logic [DATA_W-1:0] root;
        logic [DATA_W-1:0] iroot;
        logic [DATA_W-1:0] isz;
    } cfg_t;

    // Modular multiplier request and response
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
    } mm_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] res;
    } mm_rsp_t;

endpackage

`default_nettype wire

// File: design/npm_in_if.sv
// Input channel: one coefficient pair per word.
// Depends on npm_pkg.
`default_nettype none

interface npm_in_if;
    logic                        valid;
    logic                        ready;
    logic [npm_pkg::DATA_W-1:0]  a_coef;
    logic [npm_pkg::DATA_W-1:0]  b_coef;
    logic                        last_in;

    modport source (output valid, a_coef, b_coef, last_in, input ready);
    modport sink   (input valid, a_coef, b_coef, last_in, output ready);
endinterface

`default_nettype wire

// File: design/npm_out_if.sv
// Output channel: one product coefficient per word.
// Depends on npm_pkg.
`default_nettype none

interface npm_out_if;
    logic                        valid;
    logic                        ready;
    logic [npm_pkg::DATA_W-1:0]  product_coef;
    logic                        last_out;

    modport source (output valid, product_coef, last_out, input ready);
    modport sink   (input valid, product_coef, last_out, output ready);
endinterface

`default_nettype wire

// File: design/npm_mem.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module npm_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 31
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/npm_mulmod.sv
// Bit-serial modular multiplier: x * y mod p, one bit of x per cycle.
// y must already be below p. Depends on npm_pkg.
`default_nettype none

module npm_mulmod (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire npm_pkg::mm_req_t           req,
    input  wire logic [npm_pkg::DATA_W-1:0] p,
    output npm_pkg::mm_rsp_t                rsp
);

    localparam int DW = npm_pkg::DATA_W;
    localparam int NW = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [NW-1:0] cnt_reg;
    logic [DW-1:0] x_reg;
    logic [DW-1:0] y_reg;
    logic [DW-1:0] r_reg;

    logic [DW+1:0] sum;
    logic [DW+1:0] two_p;
    logic [DW+1:0] one_p;
    logic [DW-1:0] r_next;

    // One step: r = (2r + bit * y) mod p, the sum stays below 3p
    always_comb
    begin
        two_p = {1'b0, p, 1'b0};
        one_p = {2'b00, p};
        sum   = {1'b0, r_reg, 1'b0} + (x_reg[DW-1] ? {2'b00, y_reg} : '0);
        if (sum >= two_p)
        begin
            r_next = DW'(sum - two_p);
        end
        else if (sum >= one_p)
        begin
            r_next = DW'(sum - one_p);
        end
        else
        begin
            r_next = DW'(sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= NW'(DW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Operand and accumulator
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= req.x;
            y_reg <= req.y;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[DW-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.res  = r_reg;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("multiplier done without a run");
`endif

endmodule

`default_nettype wire

// File: design/npm_seq.sv
// Sequencer of the NTT multiplier: loading, bit-reversal, butterflies,
// pointwise product, scaling and output. Depends on npm_pkg.
`default_nettype none

module npm_seq #(
    parameter int MAX_POINTS = npm_pkg::MAX_POINTS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire npm_pkg::cfg_t              cfg,
    // input words
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [npm_pkg::DATA_W-1:0] in_a,
    input  wire logic [npm_pkg::DATA_W-1:0] in_b,
    input  wire logic                       in_last,
    // output words
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [npm_pkg::DATA_W-1:0] out_coef,
    output logic                            out_last,
    // modular multiplier
    output npm_pkg::mm_req_t                mm_req,
    input  wire npm_pkg::mm_rsp_t           mm_rsp,
    // stores
    output logic                            we_a,
    output logic                            we_b,
    output logic [$clog2(MAX_POINTS)-1:0]   waddr,
    output logic [npm_pkg::DATA_W-1:0]      wdata_a,
    output logic [npm_pkg::DATA_W-1:0]      wdata_b,
    output logic [$clog2(MAX_POINTS)-1:0]   raddr,
    input  wire logic [npm_pkg::DATA_W-1:0] rdata_a,
    input  wire logic [npm_pkg::DATA_W-1:0] rdata_b
);

    localparam int DW    = npm_pkg::DATA_W;
    localparam int LW    = npm_pkg::LOG_W;
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int MAXLG = $clog2(MAX_POINTS + 1) - 1;

    npm_pkg::state_t state_reg, state_next;
    npm_pkg::state_t ret_reg, ret_next;
    npm_pkg::phase_t phase_reg, phase_next;

    logic [CW-1:0] load_count_reg, load_count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [AW-1:0] k_reg, k_next;
    logic [LW-1:0] s_reg, s_next;
    logic [LW-1:0] sq_reg, sq_next;
    logic [DW-1:0] w_reg, w_next;
    logic [DW-1:0] wl_reg, wl_next;
    logic [DW-1:0] t_reg, t_next;
    logic [DW-1:0] ua_reg, ua_next;
    logic [DW-1:0] ub_reg, ub_next;
    logic [DW-1:0] isz_reg, isz_next;
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] out_coef_reg, out_coef_next;
    logic          out_last_reg, out_last_next;

    logic [CW-1:0] n_w;
    logic [AW-1:0] half_n;
    logic [AW-1:0] i_addr;
    logic [AW-1:0] rev_j;
    logic [AW-1:0] half_s;
    logic [AW-1:0] bf_i;
    logic [AW-1:0] bf_a;
    logic [AW-1:0] bf_b;
    logic [DW-1:0] cur;
    logic [DW-1:0] one_w;
    logic [DW:0]   add_s;
    logic [DW:0]   sub_s;
    logic [DW-1:0] add_m;
    logic [DW-1:0] sub_m;
    logic          wr_en;
    logic          wr_sel_b;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          mask_act;

    // Size, indexes and butterfly addresses
    always_comb
    begin
        n_w    = CW'(1) << cfg.lg;
        half_n = AW'(n_w >> 1);
        i_addr = i_reg[AW-1:0];
        rev_j  = '0;
        for (int k = 0; k < MAXLG; k++)
        begin
            if (k < int'(cfg.lg))
            begin
                rev_j[int'(cfg.lg) - 1 - k] = i_reg[k];
            end
        end
        half_s = AW'(1) << (s_reg - 1'b1);
        bf_i   = k_reg & (half_s - 1'b1);
        bf_a   = ((k_reg >> (s_reg - 1'b1)) << s_reg) | bf_i;
        bf_b   = bf_a | half_s;
        one_w  = DW'(cfg.one);
        cur    = (phase_reg == npm_pkg::PH_FWD_B) ? rdata_b : rdata_a;
        mask_act = (phase_reg != npm_pkg::PH_INV);
    end

    // Butterfly sum and difference mod p
    always_comb
    begin
        add_s = {1'b0, ua_reg} + {1'b0, mm_rsp.res};
        add_m = (add_s >= {1'b0, cfg.p}) ? DW'(add_s - {1'b0, cfg.p}) : DW'(add_s);
        sub_s = {1'b0, ua_reg} + {1'b0, cfg.p} - {1'b0, mm_rsp.res};
        sub_m = (sub_s >= {1'b0, cfg.p}) ? DW'(sub_s - {1'b0, cfg.p}) : DW'(sub_s);
    end

    // Next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        phase_next      = phase_reg;
        load_count_next = load_count_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        s_next          = s_reg;
        sq_next         = sq_reg;
        w_next          = w_reg;
        wl_next         = wl_reg;
        t_next          = t_reg;
        ua_next         = ua_reg;
        ub_next         = ub_reg;
        isz_next        = isz_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_coef_next   = out_coef_reg;
        out_last_next   = out_last_reg;
        mm_req          = '0;
        in_ready        = 1'b0;
        raddr           = '0;
        wr_en           = 1'b0;
        wr_sel_b        = (phase_reg == npm_pkg::PH_FWD_B);
        wr_addr         = '0;
        wr_data         = '0;
        we_a            = 1'b0;
        we_b            = 1'b0;
        waddr           = '0;
        wdata_a         = '0;
        wdata_b         = '0;

        case (state_reg)
            npm_pkg::S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (load_count_reg < n_w)
                    begin
                        we_a            = 1'b1;
                        we_b            = 1'b1;
                        waddr           = load_count_reg[AW-1:0];
                        wdata_a         = in_a;
                        wdata_b         = in_b;
                        load_count_next = load_count_reg + 1'b1;
                    end
                    if (in_last)
                    begin
                        phase_next = npm_pkg::PH_FWD_A;
                        state_next = npm_pkg::S_TX_INIT;
                    end
                end
            end

            npm_pkg::S_MUL:
            begin
                if (mm_rsp.done)
                begin
                    state_next = ret_reg;
                end
            end

            // reduce the root of this transform
            npm_pkg::S_TX_INIT:
            begin
                mm_req.start = 1'b1;
                mm_req.x     = (phase_reg == npm_pkg::PH_INV) ? cfg.iroot : cfg.root;
                mm_req.y     = one_w;
                ret_next     = npm_pkg::S_TX_W;
                state_next   = npm_pkg::S_MUL;
            end

            npm_pkg::S_TX_W:
            begin
                w_next     = mm_rsp.res;
                i_next     = '0;
                state_next = npm_pkg::S_PERM_RD;
            end

            // bit-reversal swap, reducing both entries on the way
            npm_pkg::S_PERM_RD:
            begin
                if (i_reg == n_w)
                begin
                    s_next     = LW'(1);
                    state_next = npm_pkg::S_STAGE_INIT;
                end
                else if (i_addr > rev_j)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    raddr      = i_addr;
                    state_next = npm_pkg::S_PERM_RD2;
                end
            end

            npm_pkg::S_PERM_RD2:
            begin
                raddr      = rev_j;
                ua_next    = (mask_act && i_reg >= load_count_reg) ? '0 : cur;
                state_next = npm_pkg::S_PERM_RD3;
            end

            npm_pkg::S_PERM_RD3:
            begin
                ub_next      = (mask_act && CW'(rev_j) >= load_count_reg) ? '0 : cur;
                mm_req.start = 1'b1;
                mm_req.x     = ua_reg;
                mm_req.y     = one_w;
                ret_next     = npm_pkg::S_PERM_R1;
                state_next   = npm_pkg::S_MUL;
            end

            npm_pkg::S_PERM_R1:
            begin
                ua_next      = mm_rsp.res;
                mm_req.start = 1'b1;
                mm_req.x     = ub_reg;
                mm_req.y     = one_w;
                ret_next     = npm_pkg::S_PERM_R2;
                state_next   = npm_pkg::S_MUL;
            end

            npm_pkg::S_PERM_R2:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_addr;
                wr_data    = mm_rsp.res;
                state_next = npm_pkg::S_PERM_WR;
            end

            npm_pkg::S_PERM_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = rev_j;
                wr_data    = ua_reg;
                i_next     = i_reg + 1'b1;
                state_next = npm_pkg::S_PERM_RD;
            end

            // stage start, or end of the transform
            npm_pkg::S_STAGE_INIT:
            begin
                if (s_reg > cfg.lg)
                begin
                    case (phase_reg)
                        npm_pkg::PH_FWD_A:
                        begin
                            phase_next = npm_pkg::PH_FWD_B;
                            state_next = npm_pkg::S_TX_INIT;
                        end
                        npm_pkg::PH_FWD_B:
                        begin
                            i_next     = '0;
                            state_next = npm_pkg::S_PW_RD;
                        end
                        default:
                        begin
                            state_next = npm_pkg::S_OUT_INIT;
                        end
                    endcase
                end
                else
                begin
                    wl_next    = w_reg;
                    sq_next    = cfg.lg - s_reg;
                    state_next = npm_pkg::S_SQ;
                end
            end

            // stage root: square once per stage still to come
            npm_pkg::S_SQ:
            begin
                if (sq_reg == '0)
                begin
                    k_next     = '0;
                    state_next = npm_pkg::S_BF_RD;
                end
                else
                begin
                    mm_req.start = 1'b1;
                    mm_req.x     = wl_reg;
                    mm_req.y     = wl_reg;
                    ret_next     = npm_pkg::S_SQ_W;
                    state_next   = npm_pkg::S_MUL;
                end
            end

            npm_pkg::S_SQ_W:
            begin
                wl_next    = mm_rsp.res;
                sq_next    = sq_reg - 1'b1;
                state_next = npm_pkg::S_SQ;
            end

            // butterflies
            npm_pkg::S_BF_RD:
            begin
                if (k_reg == half_n)
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = npm_pkg::S_STAGE_INIT;
                end
                else
                begin
                    raddr = bf_a;
                    if (bf_i == '0)
                    begin
                        t_next = one_w;
                    end
                    state_next = npm_pkg::S_BF_RD2;
                end
            end

            npm_pkg::S_BF_RD2:
            begin
                raddr      = bf_b;
                ua_next    = cur;
                state_next = npm_pkg::S_BF_RD3;
            end

            npm_pkg::S_BF_RD3:
            begin
                mm_req.start = 1'b1;
                mm_req.x     = cur;
                mm_req.y     = t_reg;
                ret_next     = npm_pkg::S_BF_X;
                state_next   = npm_pkg::S_MUL;
            end

            npm_pkg::S_BF_X:
            begin
                wr_en        = 1'b1;
                wr_addr      = bf_a;
                wr_data      = add_m;
                ub_next      = sub_m;
                mm_req.start = 1'b1;
                mm_req.x     = t_reg;
                mm_req.y     = wl_reg;
                ret_next     = npm_pkg::S_BF_T;
                state_next   = npm_pkg::S_MUL;
            end

            npm_pkg::S_BF_T:
            begin
                t_next     = mm_rsp.res;
                wr_en      = 1'b1;
                wr_addr    = bf_b;
                wr_data    = ub_reg;
                k_next     = k_reg + 1'b1;
                state_next = npm_pkg::S_BF_RD;
            end

            // pointwise product into the first store
            npm_pkg::S_PW_RD:
            begin
                if (i_reg == n_w)
                begin
                    phase_next = npm_pkg::PH_INV;
                    state_next = npm_pkg::S_TX_INIT;
                end
                else
                begin
                    raddr      = i_addr;
                    state_next = npm_pkg::S_PW_RD2;
                end
            end

            npm_pkg::S_PW_RD2:
            begin
                mm_req.start = 1'b1;
                mm_req.x     = rdata_a;
                mm_req.y     = rdata_b;
                ret_next     = npm_pkg::S_PW_WR;
                state_next   = npm_pkg::S_MUL;
            end

            npm_pkg::S_PW_WR:
            begin
                wr_en      = 1'b1;
                wr_sel_b   = 1'b0;
                wr_addr    = i_addr;
                wr_data    = mm_rsp.res;
                i_next     = i_reg + 1'b1;
                state_next = npm_pkg::S_PW_RD;
            end

            // scaling and output
            npm_pkg::S_OUT_INIT:
            begin
                mm_req.start = 1'b1;
                mm_req.x     = cfg.isz;
                mm_req.y     = one_w;
                ret_next     = npm_pkg::S_OUT_W;
                state_next   = npm_pkg::S_MUL;
            end

            npm_pkg::S_OUT_W:
            begin
                isz_next   = mm_rsp.res;
                i_next     = '0;
                state_next = npm_pkg::S_OUT_RD;
            end

            npm_pkg::S_OUT_RD:
            begin
                raddr      = i_addr;
                state_next = npm_pkg::S_OUT_RD2;
            end

            npm_pkg::S_OUT_RD2:
            begin
                mm_req.start = 1'b1;
                mm_req.x     = rdata_a;
                mm_req.y     = isz_reg;
                ret_next     = npm_pkg::S_OUT_EMIT;
                state_next   = npm_pkg::S_MUL;
            end

            npm_pkg::S_OUT_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_coef_next  = mm_rsp.res;
                    out_last_next  = (i_reg == n_w - 1'b1);
                    if (i_reg == n_w - 1'b1)
                    begin
                        load_count_next = '0;
                        state_next      = npm_pkg::S_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = npm_pkg::S_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = npm_pkg::S_LOAD;
            end
        endcase

        // computation writes go to the store of the running transform, pointwise products to the first store
        if (wr_en)
        begin
            we_a    = !wr_sel_b;
            we_b    = wr_sel_b;
            waddr   = wr_addr;
            wdata_a = wr_data;
            wdata_b = wr_data;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= npm_pkg::S_LOAD;
            ret_reg        <= npm_pkg::S_LOAD;
            phase_reg      <= npm_pkg::PH_FWD_A;
            load_count_reg <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            s_reg          <= '0;
            sq_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            phase_reg      <= phase_next;
            load_count_reg <= load_count_next;
            i_reg          <= i_next;
            k_reg          <= k_next;
            s_reg          <= s_next;
            sq_reg         <= sq_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Data registers
    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        wl_reg       <= wl_next;
        t_reg        <= t_next;
        ua_reg       <= ua_next;
        ub_reg       <= ub_next;
        isz_reg      <= isz_next;
        out_coef_reg <= out_coef_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_coef  = out_coef_reg;
    assign out_last  = out_last_reg;

`ifndef ASSERT_OFF
    a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        mm_req.start |-> !mm_rsp.busy)
        else $error("multiplier started while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= CW'(MAX_POINTS))
        else $error("load count past store depth");

    a_run_ends_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == npm_pkg::S_OUT_EMIT && state_next == npm_pkg::S_LOAD)
        |=> (out_valid_reg && out_last_reg))
        else $error("run ended without a marked last word");
`endif

endmodule

`default_nettype wire

// File: design/ntt_polynomial_multiply.sv
// Cyclic polynomial multiplier by radix-2 NTT. Each input word loads one
// coefficient pair. The word marked last starts a run: both stores are
// reduced and bit-reverse permuted, forward transformed, multiplied
// pointwise, inverse transformed and scaled, then the n = 2^log_size product
// words leave in order. All modular products go through one bit-serial
// multiplier, and no input word is taken while a run lasts.
// Depends on npm_pkg, npm_in_if, npm_out_if, npm_mem, npm_mulmod, npm_seq.
`default_nettype none

module ntt_polynomial_multiply #(
    parameter int MAX_POINTS = npm_pkg::MAX_POINTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    npm_in_if.sink                               coefs,
    npm_out_if.source                            products,
    input  wire logic                            cfg_we,
    input  wire logic [npm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [npm_pkg::DATA_W-1:0]      cfg_data
);

    localparam int DW    = npm_pkg::DATA_W;
    localparam int LW    = npm_pkg::LOG_W;
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int MAXLG = $clog2(MAX_POINTS + 1) - 1;

    logic [LW-1:0] log_size_reg;
    logic [DW-1:0] modulus_reg;
    logic [DW-1:0] root_reg;
    logic [DW-1:0] inverse_root_reg;
    logic [DW-1:0] inverse_size_reg;

    npm_pkg::cfg_t    cfg;
    npm_pkg::mm_req_t mm_req;
    npm_pkg::mm_rsp_t mm_rsp;

    logic          we_a;
    logic          we_b;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata_a;
    logic [DW-1:0] wdata_b;
    logic [AW-1:0] raddr;
    logic [DW-1:0] rdata_a;
    logic [DW-1:0] rdata_b;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_size_reg     <= npm_pkg::LOG_SIZE_RST;
            modulus_reg      <= npm_pkg::MODULUS_RST;
            root_reg         <= npm_pkg::FACTOR_RST;
            inverse_root_reg <= npm_pkg::FACTOR_RST;
            inverse_size_reg <= npm_pkg::FACTOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                npm_pkg::REG_LOG_SIZE:     log_size_reg     <= cfg_data[LW-1:0];
                npm_pkg::REG_MODULUS:      modulus_reg      <= cfg_data;
                npm_pkg::REG_ROOT:         root_reg         <= cfg_data;
                npm_pkg::REG_INVERSE_ROOT: inverse_root_reg <= cfg_data;
                npm_pkg::REG_INVERSE_SIZE: inverse_size_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Size clamped to the store depth; a zero modulus works as one
    always_comb
    begin
        cfg.lg    = (log_size_reg > LW'(MAXLG)) ? LW'(MAXLG) : log_size_reg;
        cfg.p     = (modulus_reg == '0) ? DW'(1) : modulus_reg;
        cfg.one   = (modulus_reg > DW'(1));
        cfg.root  = root_reg;
        cfg.iroot = inverse_root_reg;
        cfg.isz   = inverse_size_reg;
    end

    npm_mem #(.DEPTH(MAX_POINTS), .AW(AW), .W(DW)) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata_a),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    npm_mem #(.DEPTH(MAX_POINTS), .AW(AW), .W(DW)) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata_b),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    npm_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .p     (cfg.p),
        .rsp   (mm_rsp)
    );

    npm_seq #(.MAX_POINTS(MAX_POINTS)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (coefs.valid),
        .in_ready  (coefs.ready),
        .in_a      (coefs.a_coef),
        .in_b      (coefs.b_coef),
        .in_last   (coefs.last_in),
        .out_valid (products.valid),
        .out_ready (products.ready),
        .out_coef  (products.product_coef),
        .out_last  (products.last_out),
        .mm_req    (mm_req),
        .mm_rsp    (mm_rsp),
        .we_a      (we_a),
        .we_b      (we_b),
        .waddr     (waddr),
        .wdata_a   (wdata_a),
        .wdata_b   (wdata_b),
        .raddr     (raddr),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b)
    );

endmodule

`default_nettype wire
